[rtl/cspc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cspc_pkg: shared types and constants of the column to span converter
// Holds the column command passed from the front end to the back end, the
// back end sequencer states and the fixed field widths.
// ----------------------------------------------------------------------------
package cspc_pkg;

	// default number of screen rows in the span start store
	localparam int ROWS_DEFAULT = 64;

	// fixed field widths
	localparam int X_W   = 10;
	localparam int ROW_W = 8;

	// columns that may wait between front and back
	localparam int QUEUE_DEPTH = 4;

	// top row code of an empty column
	localparam logic [ROW_W-1:0] EMPTY_TOP = 8'hff;

	// one classified column: x and the four row runs it closes and opens
	typedef struct packed {
		logic [X_W-1:0]   x;
		logic             ct_v;   // close from the top edge, ascending
		logic [ROW_W-1:0] ct_lo;
		logic [ROW_W-1:0] ct_hi;
		logic             cb_v;   // close from the bottom edge, descending
		logic [ROW_W-1:0] cb_hi;
		logic [ROW_W-1:0] cb_lo;
		logic             ot_v;   // open at the top edge, ascending
		logic [ROW_W-1:0] ot_lo;
		logic [ROW_W-1:0] ot_hi;
		logic             ob_v;   // open at the bottom edge, descending
		logic [ROW_W-1:0] ob_hi;
		logic [ROW_W-1:0] ob_lo;
	} cmd_t;

	// back end sequencer phases, in order of execution
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CT,
		ST_CB,
		ST_OT,
		ST_OB
	} seq_state_t;

endpackage
`default_nettype wire

[rtl/cspc_col_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cspc_col_if: column channel
// Carries one column item (x, covered row range, first column flag).
// ----------------------------------------------------------------------------
interface cspc_col_if;
	logic       valid;
	logic       ready;
	logic [9:0] column_x;
	logic [7:0] top_row;
	logic [7:0] bottom_row;
	logic       first_column;

	modport source (
		output valid, column_x, top_row, bottom_row, first_column,
		input  ready
	);

	modport sink (
		input  valid, column_x, top_row, bottom_row, first_column,
		output ready
	);
endinterface
`default_nettype wire

[rtl/cspc_span_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cspc_span_if: span channel
// Carries one finished horizontal span item.
// ----------------------------------------------------------------------------
interface cspc_span_if;
	logic       valid;
	logic       ready;
	logic [7:0] span_row;
	logic [9:0] span_first_x;
	logic [8:0] span_last_x;
	logic       last_of_run;

	modport source (
		output valid, span_row, span_first_x, span_last_x, last_of_run,
		input  ready
	);

	modport sink (
		input  valid, span_row, span_first_x, span_last_x, last_of_run,
		output ready
	);
endinterface
`default_nettype wire

[rtl/cspc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cspc_ram: generic single write, single read RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is enabled.
// ----------------------------------------------------------------------------
module cspc_ram import cspc_pkg::*; #(
	parameter int WIDTH = X_W,
	parameter int DEPTH = ROWS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[rtl/cspc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cspc_queue: command queue between front and back end
// Small FIFO of classified columns so that each side can stall on its own.
// ----------------------------------------------------------------------------
module cspc_queue import cspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/cspc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cspc_front: column intake and classification
// Normalizes the column range, compares it with the previous column's range
// and works out the four row runs to close and open. Keeps the previous range.
// ----------------------------------------------------------------------------
module cspc_front import cspc_pkg::*; #(
	parameter int ROWS = ROWS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	cspc_col_if.sink cols,
	input  logic q_full,
	output logic q_push,
	output cmd_t q_cmd
);

	localparam logic [8:0] ROWS9     = 9'(ROWS);
	localparam logic [8:0] LAST_ROW9 = 9'(ROWS - 1);

	logic [ROW_W-1:0] prev_top_q;
	logic [ROW_W-1:0] prev_bot_q;

	logic       empty_col;
	logic [8:0] t1, b1, t2, b2;
	logic [8:0] ct_hi, t1p, cb_lo, b1p, ot_hi, t2p, ob_lo;
	logic       ct_v, cb_v, ot_v, ob_v;

	assign cols.ready = !q_full;
	assign q_push     = cols.valid && !q_full;

	// range normalization and run classification (9-bit to hold row + 1)
	always_comb begin
		t1 = cols.first_column ? {1'b0, EMPTY_TOP} : {1'b0, prev_top_q};
		b1 = cols.first_column ? 9'd0 : {1'b0, prev_bot_q};

		empty_col = (cols.top_row == EMPTY_TOP) || ({1'b0, cols.top_row} >= ROWS9);
		t2 = empty_col ? {1'b0, EMPTY_TOP} : {1'b0, cols.top_row};
		if (empty_col) begin
			b2 = 9'd0;
		end else if ({1'b0, cols.bottom_row} >= ROWS9) begin
			b2 = LAST_ROW9;
		end else begin
			b2 = {1'b0, cols.bottom_row};
		end

		// rows left at the top edge
		ct_v  = (t1 < t2) && (t1 <= b1);
		ct_hi = ((t2 - 9'd1) < b1) ? (t2 - 9'd1) : b1;
		t1p   = ct_v ? ct_hi + 9'd1 : t1;

		// rows left at the bottom edge
		cb_v  = (b1 > b2) && (b1 >= t1p);
		cb_lo = ((b2 + 9'd1) > t1p) ? (b2 + 9'd1) : t1p;
		b1p   = cb_v ? cb_lo - 9'd1 : b1;

		// rows entered at the top edge
		ot_v  = (t2 < t1p) && (t2 <= b2);
		ot_hi = ((t1p - 9'd1) < b2) ? (t1p - 9'd1) : b2;
		t2p   = ot_v ? ot_hi + 9'd1 : t2;

		// rows entered at the bottom edge
		ob_v  = (b2 > b1p) && (b2 >= t2p);
		ob_lo = ((b1p + 9'd1) > t2p) ? (b1p + 9'd1) : t2p;
	end

	// command to the queue
	always_comb begin
		q_cmd.x     = cols.column_x;
		q_cmd.ct_v  = ct_v;
		q_cmd.ct_lo = t1[7:0];
		q_cmd.ct_hi = ct_hi[7:0];
		q_cmd.cb_v  = cb_v;
		q_cmd.cb_hi = b1[7:0];
		q_cmd.cb_lo = cb_lo[7:0];
		q_cmd.ot_v  = ot_v;
		q_cmd.ot_lo = t2[7:0];
		q_cmd.ot_hi = ot_hi[7:0];
		q_cmd.ob_v  = ob_v;
		q_cmd.ob_hi = b2[7:0];
		q_cmd.ob_lo = ob_lo[7:0];
	end

	// previous column range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_top_q <= EMPTY_TOP;
			prev_bot_q <= '0;
		end else if (q_push) begin
			prev_top_q <= t2[7:0];
			prev_bot_q <= b2[7:0];
		end
	end

endmodule
`default_nettype wire

[rtl/cspc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cspc_back: span sequencer
// Takes one classified column from the queue and walks its runs one row per
// cycle while the span output is not stalled: closed rows read their start x
// from the store and leave as spans; opened rows write the column x there.
// ----------------------------------------------------------------------------
module cspc_back import cspc_pkg::*; #(
	parameter int ROWS = ROWS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t q_head,
	output logic q_pop,
	cspc_span_if.source spans
);

	localparam int AW = $clog2(ROWS);

	typedef struct packed {
		seq_state_t       state;
		logic [ROW_W-1:0] row;
	} pick_t;

	// first phase at or after 'from' that has work, with its starting row
	function automatic pick_t pick_phase(cmd_t c, seq_state_t from);
		pick_t p;
		p.state = ST_IDLE;
		p.row   = '0;
		if (from <= ST_CT && c.ct_v) begin
			p.state = ST_CT;
			p.row   = c.ct_lo;
		end else if (from <= ST_CB && c.cb_v) begin
			p.state = ST_CB;
			p.row   = c.cb_hi;
		end else if (from <= ST_OT && c.ot_v) begin
			p.state = ST_OT;
			p.row   = c.ot_lo;
		end else if (c.ob_v) begin
			p.state = ST_OB;
			p.row   = c.ob_hi;
		end
		return p;
	endfunction

	seq_state_t       state_q, state_d;
	logic [ROW_W-1:0] row_q, row_d;
	cmd_t             cmd_q;
	pick_t            nxt;
	logic             cmd_load;
	logic             issue_ok;

	logic             rd_en, wr_en, emit_last;
	logic [X_W-1:0]   rd_data;
	logic [X_W-1:0]   x_m1;

	logic             valid_s1;
	logic [ROW_W-1:0] row_s1;
	logic [8:0]       lastx_s1;
	logic             last_s1;

	assign issue_ok = !valid_s1 || spans.ready;
	assign x_m1     = cmd_q.x - 10'd1;
	assign q_pop    = cmd_load;

	// next state
	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		cmd_load = 1'b0;
		nxt      = '{state: ST_IDLE, row: '0};
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					cmd_load = 1'b1;
					nxt      = pick_phase(q_head, ST_CT);
					state_d  = nxt.state;
					row_d    = nxt.row;
				end
			end
			ST_CT: begin
				if (issue_ok) begin
					if (row_q == cmd_q.ct_hi) begin
						nxt     = pick_phase(cmd_q, ST_CB);
						state_d = nxt.state;
						row_d   = nxt.row;
					end else begin
						row_d = row_q + 8'd1;
					end
				end
			end
			ST_CB: begin
				if (issue_ok) begin
					if (row_q == cmd_q.cb_lo) begin
						nxt     = pick_phase(cmd_q, ST_OT);
						state_d = nxt.state;
						row_d   = nxt.row;
					end else begin
						row_d = row_q - 8'd1;
					end
				end
			end
			ST_OT: begin
				if (row_q == cmd_q.ot_hi) begin
					nxt     = pick_phase(cmd_q, ST_OB);
					state_d = nxt.state;
					row_d   = nxt.row;
				end else begin
					row_d = row_q + 8'd1;
				end
			end
			ST_OB: begin
				if (row_q == cmd_q.ob_lo) begin
					state_d = ST_IDLE;
				end else begin
					row_d = row_q - 8'd1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// store access and end-of-column mark
	always_comb begin
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			ST_CT: begin
				rd_en     = issue_ok;
				emit_last = (row_q == cmd_q.ct_hi) && !cmd_q.cb_v;
			end
			ST_CB: begin
				rd_en     = issue_ok;
				emit_last = (row_q == cmd_q.cb_lo);
			end
			ST_OT, ST_OB: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// span start store
	cspc_ram #(
		.WIDTH (X_W),
		.DEPTH (ROWS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (row_q[AW-1:0]),
		.wr_data (cmd_q.x),
		.rd_en   (rd_en),
		.rd_addr (row_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			if (rd_en) begin
				valid_s1 <= 1'b1;
			end else if (spans.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// column command and output stage payload
	always_ff @(posedge clk) begin
		if (cmd_load) begin
			cmd_q <= q_head;
		end
		if (rd_en) begin
			row_s1   <= row_q;
			lastx_s1 <= x_m1[8:0];
			last_s1  <= emit_last;
		end
	end

	assign spans.valid        = valid_s1;
	assign spans.span_row     = row_s1;
	assign spans.span_first_x = rd_data;
	assign spans.span_last_x  = lastx_s1;
	assign spans.last_of_run  = last_s1;

endmodule
`default_nettype wire

[rtl/column_to_span_converter_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// column_to_span_converter_core: floor/ceiling column to span converter
// Turns a stream of column row ranges into finished horizontal spans.
// ----------------------------------------------------------------------------
//
//  port    dir  item                                          size
//  cols    in   column_x, top_row, bottom_row, first_column   10/8/8/1
//  spans   out  span_row, span_first_x, span_last_x,          8/10/9/1
//               last_of_run
//
// The front end classifies a column in the cycle it is accepted and queues
// it (up to four columns wait). The back end takes a column from the queue
// in its idle state, then steps through each closed and each opened row in
// turn at the single store port, and only then takes the next column.
// Reset clears the previous column range (empty), the queue and the sequencer;
// the span start store is not cleared. A stalled span output holds the back
// end in its close phases; the front end keeps accepting until the queue fills.
//
module column_to_span_converter_core import cspc_pkg::*; #(
	parameter int ROWS = ROWS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	cspc_col_if.sink    cols,
	cspc_span_if.source spans
);

	logic q_push, q_pop, q_full, q_empty;
	cmd_t q_cmd, q_head;

	// intake and classification
	cspc_front #(
		.ROWS (ROWS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cols   (cols),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_cmd)
	);

	// column queue
	cspc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	// span sequencer and store
	cspc_back #(
		.ROWS (ROWS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.spans   (spans)
	);

	// the sequencer only takes a column that is there
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("column taken from an empty queue");

	// top close run is ordered and inside the store
	a_ct_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && q_head.ct_v) |->
			(q_head.ct_lo <= q_head.ct_hi) && ({1'b0, q_head.ct_hi} < 9'(ROWS)))
		else $error("bad top close run");

	// bottom close run is ordered and inside the store
	a_cb_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && q_head.cb_v) |->
			(q_head.cb_lo <= q_head.cb_hi) && ({1'b0, q_head.cb_hi} < 9'(ROWS)))
		else $error("bad bottom close run");

	// a span that does not end its column is followed at once by the next
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(spans.valid && spans.ready && !spans.last_of_run) |=> spans.valid)
		else $error("span run broken before its last span");

endmodule
`default_nettype wire
